FILE: design/bmm_pkg.sv
`default_nettype none

package bmm_pkg;

    // Node ids and mate ids on the channels are fixed at ten bits.
    localparam int ID_W = 10;

    typedef enum logic [1:0] {
        MODE_QUERY   = 2'd0,
        MODE_MATCH   = 2'd1,
        MODE_UNMATCH = 2'd2,
        MODE_LIST    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FREE   = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_WRITE_V,
        S_LIST
    } t_state;

    // One slot of a mate row.
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
    } t_slot;

    typedef struct packed {
        logic [1:0]      mode;
        logic [ID_W-1:0] node_u;
        logic [ID_W-1:0] node_v;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic            pair_matched;
        logic            u_unmatched;
        logic            mate_valid;
        logic [ID_W-1:0] mate_id;
        logic            last;
    } t_rsp;

    // Outcome of evaluating one pair request against the two rows.
    typedef struct packed {
        logic [1:0] status;
        logic       pair_matched;
        logic       u_unmatched;
        logic       write_u;
        logic       write_v;
    } t_eval;

endpackage

`default_nettype wire

FILE: design/bmm_req_if.sv
`default_nettype none

interface bmm_req_if;
    logic          valid;
    logic          ready;
    bmm_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/bmm_rsp_if.sv
`default_nettype none

interface bmm_rsp_if;
    logic          valid;
    logic          ready;
    bmm_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/b_matching_mate_table.sv
`default_nettype none

// Channel | Dir | Modport | Payload
// i_req   | in  | sink    | mode, node_u, node_v
// o_rsp   | out | source  | status, pair_matched, u_unmatched, mate_valid, mate_id, last
//
// After reset the row memory is swept to empty, one row per cycle, through
// all NODES rows; requests are not taken during the sweep.
// A query is answered from the evaluate state. A successful match or
// unmatch of two different nodes writes row u there and then row v in the
// write-v state, as the row memory has a single write port. A list sends one
// response per slot. A stalled response holds the evaluate and list states.
module b_matching_mate_table #(
    parameter int NODES = 1024,
    parameter int SLOTS = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bmm_req_if.sink    i_req,
    bmm_rsp_if.source  o_rsp
);

    localparam int AW = $clog2(NODES);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef bmm_pkg::t_slot [SLOTS-1:0] t_row;

    // Row memory: one write port, two registered read ports.
    t_row r_mem [NODES];
    t_row r_rd_u, r_rd_v;

    bmm_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_clr, n_clr;
    logic [SW-1:0]   r_k, n_k;
    logic [AW-1:0]   r_addr_u, r_addr_v;
    logic [bmm_pkg::ID_W-1:0] r_u, r_v;
    logic [1:0]      r_mode;
    logic            r_u_ok, r_v_ok;
    t_row            r_new_v;
    logic            r_out_valid, n_out_valid;
    bmm_pkg::t_rsp   r_out, n_out;

    logic            accept, out_free, out_load, list_last;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_row            wr_data;
    t_row            ev_row_u, ev_row_v;
    bmm_pkg::t_eval  ev;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign list_last = (r_k == SW'(SLOTS - 1));

    bmm_eval #(
        .SLOTS (SLOTS)
    ) u_eval (
        .i_mode   (r_mode),
        .i_node_u (r_u),
        .i_node_v (r_v),
        .i_u_ok   (r_u_ok),
        .i_v_ok   (r_v_ok),
        .i_row_u  (r_rd_u),
        .i_row_v  (r_rd_v),
        .o_row_u  (ev_row_u),
        .o_row_v  (ev_row_v),
        .o_ev     (ev)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            bmm_pkg::S_CLEAR: begin
                if (r_clr == AW'(NODES - 1)) begin
                    n_state = bmm_pkg::S_IDLE;
                end
            end
            bmm_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (i_req.data.mode == bmm_pkg::MODE_LIST) ?
                              bmm_pkg::S_LIST : bmm_pkg::S_EVAL;
                end
            end
            bmm_pkg::S_EVAL: begin
                if (out_free) begin
                    n_state = ev.write_v ? bmm_pkg::S_WRITE_V : bmm_pkg::S_IDLE;
                end
            end
            bmm_pkg::S_WRITE_V: begin
                n_state = bmm_pkg::S_IDLE;
            end
            bmm_pkg::S_LIST: begin
                if (out_free && list_last) begin
                    n_state = bmm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bmm_pkg::S_CLEAR;
            end
        endcase
    end

    // Outputs of the state machine: memory writes, response loads, counters.
    always_comb begin
        i_req.ready = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_addr_u;
        wr_data     = '0;
        out_load    = 1'b0;
        n_out       = r_out;
        n_clr       = r_clr;
        n_k         = r_k;
        case (r_state)
            bmm_pkg::S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                n_clr   = r_clr + AW'(1);
            end
            bmm_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                n_k         = '0;
            end
            bmm_pkg::S_EVAL: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    wr_en              = ev.write_u;
                    wr_data            = ev_row_u;
                    n_out              = '0;
                    n_out.status       = ev.status;
                    n_out.pair_matched = ev.pair_matched;
                    n_out.u_unmatched  = ev.u_unmatched;
                    n_out.last         = 1'b1;
                end
            end
            bmm_pkg::S_WRITE_V: begin
                wr_en   = 1'b1;
                wr_addr = r_addr_v;
                wr_data = r_new_v;
            end
            bmm_pkg::S_LIST: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    n_out            = '0;
                    n_out.status     = bmm_pkg::STAT_OK;
                    n_out.mate_valid = r_u_ok && r_rd_u[r_k].valid;
                    n_out.mate_id    = n_out.mate_valid ? r_rd_u[r_k].id : '0;
                    n_out.last       = list_last;
                    n_k              = r_k + SW'(1);
                end
            end
            default: begin
            end
        endcase
        n_out_valid = out_load || (r_out_valid && !o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bmm_pkg::S_CLEAR;
            r_clr       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // Request capture and response payload; no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_req.data.mode;
            r_u      <= i_req.data.node_u;
            r_v      <= i_req.data.node_v;
            r_addr_u <= AW'(i_req.data.node_u);
            r_addr_v <= AW'(i_req.data.node_v);
            r_u_ok   <= (32'(i_req.data.node_u) < 32'(NODES));
            r_v_ok   <= (32'(i_req.data.node_v) < 32'(NODES));
        end
        if (r_state == bmm_pkg::S_EVAL) begin
            r_new_v <= ev_row_v;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    // Row memory. Reads happen only when a request is taken, so the read data
    // holds for the rest of that request; no write is pending at that point.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            r_rd_u <= r_mem[AW'(i_req.data.node_u)];
            r_rd_v <= r_mem[AW'(i_req.data.node_v)];
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // A response is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || o_rsp.ready))
        else $error("response register overwritten");

    // No request is taken while the clearing sweep runs.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmm_pkg::S_CLEAR) |-> !i_req.ready)
        else $error("request taken during clearing sweep");

    // A two-row rewrite writes row v in the cycle after row u.
    a_second_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmm_pkg::S_EVAL && out_load && ev.write_v)
        |=> (wr_en && wr_addr == r_addr_v))
        else $error("second row write missing");

    // A failed match or unmatch leaves the memory untouched.
    a_fail_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmm_pkg::S_EVAL && out_load && ev.status != bmm_pkg::STAT_OK)
        |-> !wr_en ##1 !wr_en)
        else $error("memory written on a failed request");

    // The last list response returns the block to idle.
    a_list_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmm_pkg::S_LIST && out_load && list_last)
        |=> (r_state == bmm_pkg::S_IDLE && r_out.last))
        else $error("list did not end after its last slot");

endmodule

`default_nettype wire

FILE: design/bmm_eval.sv
`default_nettype none

// Evaluates a query, match or unmatch request against rows u and v and
// produces the rewritten rows.
module bmm_eval #(
    parameter int SLOTS = 4
) (
    input  wire logic [1:0]                     i_mode,
    input  wire logic [bmm_pkg::ID_W-1:0]       i_node_u,
    input  wire logic [bmm_pkg::ID_W-1:0]       i_node_v,
    input  wire logic                           i_u_ok,
    input  wire logic                           i_v_ok,
    input  wire bmm_pkg::t_slot [SLOTS-1:0]     i_row_u,
    input  wire bmm_pkg::t_slot [SLOTS-1:0]     i_row_v,
    output bmm_pkg::t_slot [SLOTS-1:0]          o_row_u,
    output bmm_pkg::t_slot [SLOTS-1:0]          o_row_v,
    output bmm_pkg::t_eval                      o_ev
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Returns the found flag in the top bit and the lowest set index below it.
    function automatic logic [SW:0] first_set(input logic [SLOTS-1:0] vec);
        logic          found;
        logic [SW-1:0] idx;
        found = 1'b0;
        idx   = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (vec[i] && !found) begin
                found = 1'b1;
                idx   = SW'(i);
            end
        end
        return {found, idx};
    endfunction

    logic [SLOTS-1:0] free_u, free_v, hit_u, hit_v;
    logic [SLOTS-1:0] sel_u, sel_v, sel_u2;
    logic [SW:0]      fa, fb;
    logic [SW-1:0]    a, b;
    logic             same, is_match, is_unmatch, is_query, ok;
    bmm_pkg::t_slot   slot_u, slot_v;

    assign same       = (i_node_u == i_node_v);
    assign is_match   = (i_mode == bmm_pkg::MODE_MATCH);
    assign is_unmatch = (i_mode == bmm_pkg::MODE_UNMATCH);
    assign is_query   = (i_mode == bmm_pkg::MODE_QUERY);

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            free_u[i] = !i_row_u[i].valid;
            free_v[i] = !i_row_v[i].valid;
            hit_u[i]  = i_row_u[i].valid && (i_row_u[i].id == i_node_v);
            hit_v[i]  = i_row_v[i].valid && (i_row_v[i].id == i_node_u);
        end
    end

    assign sel_u = is_match ? free_u : hit_u;
    assign sel_v = is_match ? free_v : hit_v;
    assign fa    = first_set(sel_u);
    assign a     = fa[SW-1:0];

    // For a self pair the second slot is the next candidate after the first.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            sel_u2[i] = sel_u[i] && (SW'(i) != a);
        end
    end

    assign fb = same ? first_set(sel_u2) : first_set(sel_v);
    assign b  = fb[SW-1:0];
    assign ok = i_u_ok && i_v_ok && fa[SW] && fb[SW];

    always_comb begin
        slot_u = '0;
        slot_v = '0;
        if (is_match) begin
            slot_u = '{valid: 1'b1, id: i_node_v};
            slot_v = '{valid: 1'b1, id: i_node_u};
        end
        o_row_u    = i_row_u;
        o_row_u[a] = slot_u;
        if (same) begin
            o_row_u[b] = slot_v;
        end
        o_row_v    = i_row_v;
        o_row_v[b] = slot_v;
    end

    always_comb begin
        o_ev              = '0;
        o_ev.status       = bmm_pkg::STAT_OK;
        o_ev.pair_matched = is_query && i_u_ok && (|hit_u);
        o_ev.u_unmatched  = is_query && (!i_u_ok || !i_row_u[0].valid);
        if (is_match && !ok) begin
            o_ev.status = bmm_pkg::STAT_NO_FREE;
        end
        if (is_unmatch && !ok) begin
            o_ev.status = bmm_pkg::STAT_NOT_FOUND;
        end
        o_ev.write_u = ok && (is_match || is_unmatch);
        o_ev.write_v = ok && (is_match || is_unmatch) && !same;
    end

endmodule

`default_nettype wire
